[rtl/hs_pkg.sv]
// heap sorter package: data width and cell contents type
package hs_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] data_t;

  typedef struct packed {
    logic  valid;
    data_t value;
  } hs_cell_t;

endpackage

[rtl/hs_if.sv]
// heap sorter channel interfaces: element input and sorted result output
interface hs_in_if;
  import hs_pkg::*;

  logic  valid;
  logic  ready;
  data_t value;
  logic  last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink (input valid, input value, input last_item, output ready);
endinterface

interface hs_out_if;
  import hs_pkg::*;

  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_result;
  logic  overflowed;

  modport source (output valid, output sorted_value, output last_result,
                  output overflowed, input ready);
  modport sink (input valid, input sorted_value, input last_result,
                input overflowed, output ready);
endinterface

[rtl/hs_cell.sv]
// heap sorter cell: one sorted slot, insert from the left, shift out to the left
module hs_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             drain_i,
  input  hs_pkg::data_t    new_value_i,
  input  hs_pkg::hs_cell_t left_i,
  input  logic             left_lt_i,
  input  hs_pkg::hs_cell_t right_i,
  output hs_pkg::hs_cell_t cell_o,
  output logic             lt_o
);
  import hs_pkg::*;

  logic  valid_q, valid_d;
  data_t value_q, value_d;

  // new element goes before this slot when the slot is empty or larger
  assign lt_o = !valid_q || ($signed(new_value_i) < $signed(value_q));

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (load_i && lt_o) begin
      if (left_lt_i) begin
        valid_d = left_i.valid;
        value_d = left_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = new_value_i;
      end
    end else if (drain_i) begin
      valid_d = right_i.valid;
      value_d = right_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign cell_o.valid = valid_q;
  assign cell_o.value = value_q;

endmodule

[rtl/heap_sorter_core.sv]
// heap sorter top level: systolic insertion chain with sorted drain
//
//   channel  dir  payload                                   request when
//   in_i     in   value, last_item                          valid && ready
//   out_o    out  sorted_value, last_result, overflowed     valid && ready
//
// loading takes one element per cycle; ready is high while loading
// after the last element sorted values leave one per cycle, smallest first,
// while the output is ready; a stalled output holds the chain
// no element is taken while draining
// reset empties every cell and clears the overflow flag
module heap_sorter_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  hs_in_if.sink    in_i,
  hs_out_if.source out_o
);
  import hs_pkg::*;

  typedef enum logic {
    StLoad,
    StDrain
  } state_e;

  state_e   state_q, state_d;
  logic     overflow_q, overflow_d;
  logic     in_req, out_req, full, load, drain;

  hs_cell_t cells [CAPACITY];
  logic     lts   [CAPACITY];

  assign full    = cells[CAPACITY-1].valid;
  assign in_req  = in_i.valid && in_i.ready;
  assign out_req = out_o.valid && out_o.ready;
  assign load    = in_req && !full;
  assign drain   = out_req;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    hs_cell_t left_cell, right_cell;
    logic     left_lt;

    if (g == 0) begin : g_first
      assign left_cell = '0;
      assign left_lt   = 1'b0;
    end else begin : g_mid
      assign left_cell = cells[g-1];
      assign left_lt   = lts[g-1];
    end

    if (g == CAPACITY - 1) begin : g_end
      assign right_cell = '0;
    end else begin : g_inner
      assign right_cell = cells[g+1];
    end

    hs_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .drain_i     (drain),
      .new_value_i (in_i.value),
      .left_i      (left_cell),
      .left_lt_i   (left_lt),
      .right_i     (right_cell),
      .cell_o      (cells[g]),
      .lt_o        (lts[g])
    );
  end

  always_comb begin
    state_d    = state_q;
    overflow_d = overflow_q;
    case (state_q)
      StLoad: begin
        if (in_req) begin
          if (full) begin
            overflow_d = 1'b1;
          end
          if (in_i.last_item) begin
            state_d = StDrain;
          end
        end
      end
      StDrain: begin
        if (out_req && out_o.last_result) begin
          state_d    = StLoad;
          overflow_d = 1'b0;
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      overflow_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      overflow_q <= overflow_d;
    end
  end

  assign in_i.ready         = (state_q == StLoad);
  assign out_o.valid        = (state_q == StDrain) && cells[0].valid;
  assign out_o.sorted_value = cells[0].value;
  assign out_o.last_result  = !cells[1].valid;
  assign out_o.overflowed   = overflow_q;

  // draining always has a value at the head of the chain
  a_drain_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDrain) |-> cells[0].valid)
    else $error("drain state with empty head cell");

  // head pair stays in ascending order
  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cells[0].valid && cells[1].valid) |-> (cells[0].value <= cells[1].value))
    else $error("head cells out of order");

  // occupied cells form a prefix of the chain, checked on the head pair
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cells[1].valid |-> cells[0].valid)
    else $error("gap in occupied cells");

  // final result empties the chain and clears the flag
  a_set_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_req && out_o.last_result) |=>
      (state_q == StLoad) && !overflow_q && !cells[0].valid)
    else $error("set not cleared after final result");

endmodule

[dv/testbench.sv]
// heap sorter testbench: directed and random sets checked against an in-bench sort predictor
module testbench;
  import hs_pkg::*;

  localparam int unsigned Capacity = 64;
  localparam int unsigned ItemTarget = 380;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait = 2 * Capacity + 16;
  localparam data_t MinVal = {1'b1, {(DataW-1){1'b0}}};
  localparam data_t MaxVal = {1'b0, {(DataW-1){1'b1}}};

  typedef enum int unsigned {ModeWide, ModeNarrow, ModeEdge} value_mode_e;

  typedef struct packed {
    data_t sorted_value;
    logic  last_result;
    logic  overflowed;
  } sorted_t;

  typedef struct packed {
    data_t value;
    logic  last;
    logic  fixed_exp;
    data_t exp_value;
    logic  exp_ovf;
  } plan_row_t;

  localparam int unsigned PlanLen = 20;
  localparam plan_row_t Plan [PlanLen] = '{
    '{MinVal, 1'b1, 1'b1, MinVal, 1'b0},
    '{MaxVal, 1'b1, 1'b1, MaxVal, 1'b0},
    '{data_t'(0), 1'b1, 1'b1, data_t'(0), 1'b0},
    '{data_t'(-1), 1'b1, 1'b1, data_t'(-1), 1'b0},
    '{MaxVal, 1'b0, 1'b0, data_t'(0), 1'b0},
    '{MinVal, 1'b1, 1'b0, data_t'(0), 1'b0},
    '{data_t'(7), 1'b0, 1'b0, data_t'(0), 1'b0},
    '{data_t'(7), 1'b0, 1'b0, data_t'(0), 1'b0},
    '{data_t'(7), 1'b1, 1'b0, data_t'(0), 1'b0},
    '{data_t'(3), 1'b0, 1'b0, data_t'(0), 1'b0},
    '{data_t'(2), 1'b0, 1'b0, data_t'(0), 1'b0},
    '{data_t'(1), 1'b0, 1'b0, data_t'(0), 1'b0},
    '{data_t'(0), 1'b0, 1'b0, data_t'(0), 1'b0},
    '{data_t'(-1), 1'b0, 1'b0, data_t'(0), 1'b0},
    '{MinVal, 1'b1, 1'b0, data_t'(0), 1'b0},
    '{data_t'(-5), 1'b0, 1'b0, data_t'(0), 1'b0},
    '{data_t'(100), 1'b0, 1'b0, data_t'(0), 1'b0},
    '{data_t'(-5), 1'b0, 1'b0, data_t'(0), 1'b0},
    '{MaxVal, 1'b0, 1'b0, data_t'(0), 1'b0},
    '{data_t'(0), 1'b1, 1'b0, data_t'(0), 1'b0}
  };

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  src_valid = 1'b0;
  data_t src_value = '0;
  logic  src_last = 1'b0;
  logic  sink_ready = 1'b0;

  hs_in_if  in_if ();
  hs_out_if out_if ();

  assign in_if.valid     = src_valid;
  assign in_if.value     = src_value;
  assign in_if.last_item = src_last;
  assign out_if.ready    = sink_ready;

  heap_sorter_core #(
    .CAPACITY(Capacity)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  data_t   held_set[$];
  logic    held_ovf = 1'b0;
  sorted_t sorted_q[$];
  bit      quiet = 1'b0;
  int      fail_count = 0;
  int      items_sent = 0;
  int      sets_sent = 0;
  int      overflow_sets = 0;
  int      results_seen = 0;
  int      stall_left = 0;
  int unsigned cycle_count = 0;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic data_t random_value(value_mode_e mode);
    case (mode)
      ModeNarrow: return data_t'(int'($urandom_range(0, 8)) - 4);
      ModeEdge: begin
        case ($urandom_range(0, 5))
          0: return MinVal;
          1: return MaxVal;
          2: return data_t'(0);
          3: return data_t'(-1);
          4: return MinVal + data_t'(1);
          default: return data_t'($urandom);
        endcase
      end
      default: return data_t'($urandom);
    endcase
  endfunction

  // stores an element or flags overflow; on the last, queues the set ascending if record
  task automatic collect_element(data_t v, logic last, bit record);
    data_t   srt[$];
    data_t   key;
    int      j;
    sorted_t res;
    if (held_set.size() < Capacity) held_set.push_back(v);
    else held_ovf = 1'b1;
    if (last) begin
      srt = held_set;
      for (int i = 1; i < srt.size(); i++) begin
        key = srt[i];
        j = i - 1;
        while (j >= 0 && srt[j] > key) begin
          srt[j+1] = srt[j];
          j--;
        end
        srt[j+1] = key;
      end
      if (record) begin
        for (int k = 0; k < srt.size(); k++) begin
          res.sorted_value = srt[k];
          res.last_result  = (k == srt.size() - 1);
          res.overflowed   = held_ovf;
          sorted_q.push_back(res);
        end
      end
      held_set.delete();
      held_ovf = 1'b0;
    end
  endtask

  // called at a falling edge, returns at the falling edge after the request
  task automatic send_item(data_t v, logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    src_valid <= 1'b1;
    src_value <= v;
    src_last  <= last;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    items_sent++;
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = idle_len();
      sink_ready <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    sorted_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        $error("unexpected result: sorted_value %0d", out_if.sorted_value);
        fail_count++;
      end else begin
        want = sorted_q.pop_front();
        if (out_if.sorted_value !== want.sorted_value) begin
          $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                 out_if.sorted_value);
          fail_count++;
        end
        if (out_if.last_result !== want.last_result) begin
          $error("last_result: expected %0b, got %0b", want.last_result,
                 out_if.last_result);
          fail_count++;
        end
        if (out_if.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0b, got %0b", want.overflowed,
                 out_if.overflowed);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               sorted_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    sorted_t     fixed;
    int          set_len;
    value_mode_e mode;
    int          r;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed sets
    for (int i = 0; i < PlanLen; i++) begin
      send_item(Plan[i].value, Plan[i].last);
      collect_element(Plan[i].value, Plan[i].last, !Plan[i].fixed_exp);
      if (Plan[i].fixed_exp) begin
        fixed.sorted_value = Plan[i].exp_value;
        fixed.last_result  = 1'b1;
        fixed.overflowed   = Plan[i].exp_ovf;
        sorted_q.push_back(fixed);
      end
      if (Plan[i].last) sets_sent++;
    end

    // random sets, mostly small, a few full or overfull
    while (items_sent < ItemTarget) begin
      quiet = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) set_len = $urandom_range(1, 8);
      else if (r < 88) set_len = $urandom_range(9, 40);
      else if (r < 94) set_len = Capacity;
      else set_len = $urandom_range(Capacity + 1, Capacity + 8);
      mode = value_mode_e'($urandom_range(0, 2));
      if (set_len > Capacity) overflow_sets++;
      for (int k = 0; k < set_len; k++) begin
        data_t v;
        v = random_value(mode);
        send_item(v, k == set_len - 1);
        collect_element(v, k == set_len - 1, 1'b1);
      end
      sets_sent++;
    end
    src_valid <= 1'b0;
    quiet = 1'b0;

    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (sorted_q.size() != 0) begin
      $error("%0d expected results never arrived", sorted_q.size());
      fail_count++;
    end

    $display("covered %0d sets (%0d overfull) from %0d elements, %0d sorted results checked",
             sets_sent, overflow_sets, items_sent, results_seen);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
